>>> src/pcl_pkg.sv
package pcl_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_CHECK1   = 3'd1,
    PH_WAIT1    = 3'd2,
    PH_CHECK2   = 3'd3,
    PH_WAIT2    = 3'd4,
    PH_CHECK3   = 3'd5,
    PH_WAIT3    = 3'd6,
    PH_ACCEPTED = 3'd7
  } phase_t;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_FIRST_DIGIT   = 2'd0,
    REG_SECOND_DIGIT  = 2'd1,
    REG_THIRD_DIGIT   = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } reg_idx_t;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned IDX_W   = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_RST   = 4'd1;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [TICK_W-1:0]  TICK_MAX    = 16'hFFFF;

  localparam logic [IDX_W-1:0] IDX_DIGIT1 = 2'd0;
  localparam logic [IDX_W-1:0] IDX_DIGIT2 = 2'd1;
  localparam logic [IDX_W-1:0] IDX_DIGIT3 = 2'd2;

endpackage

>>> src/pulse_count_code_lock.sv
// Code lock whose lock flag toggles on each code of three digits entered as
// counts of button presses. Each in_ transaction is one millisecond tick carrying
// the press flag; every tick gives exactly one out_ transaction with the lock
// flag and the entry phase after that tick. Logic between the state registers
// and the result register handles a tick, so a new tick is taken every cycle
// while the result register is empty or being drained; a stalled result holds
// off only the next tick. Digits and the inactivity timeout, at APB byte addresses
// 0, 4, 8 and 12, must be written only while no tick is in flight (not enforced).
module pulse_count_code_lock (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_press,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_unlocked,
  output logic [2:0]              out_phase,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pcl_pkg::*;

  logic [DIGIT_W-1:0] first_digit_r, second_digit_r, third_digit_r;
  logic [TICK_W-1:0]  timeout_r;

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0]   digit_idx_r, digit_idx_nxt;
  logic               timer_on_r, timer_on_nxt;
  logic [TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic               pending_r, pending_nxt;
  logic               unlock_r, unlock_nxt;
  logic               out_valid_r;
  logic [2:0]         out_phase_r;

  logic               in_accept;
  logic               cfg_write;
  reg_idx_t           reg_sel;
  logic [TICK_W-1:0]  elapsed_adv;
  logic               pending_in;
  logic               timed_out;
  logic [DIGIT_W-1:0] cur_digit;
  logic [COUNT_W-1:0] cur_digit_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_unlocked = unlock_r;
  assign out_phase = out_phase_r;

  // Configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_FIRST_DIGIT:   prdata = {{(32-DIGIT_W){1'b0}}, first_digit_r};
      REG_SECOND_DIGIT:  prdata = {{(32-DIGIT_W){1'b0}}, second_digit_r};
      REG_THIRD_DIGIT:   prdata = {{(32-DIGIT_W){1'b0}}, third_digit_r};
      REG_TIMEOUT_TICKS: prdata = {{(32-TICK_W){1'b0}}, timeout_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_digit_r  <= DIGIT_RST;
      second_digit_r <= DIGIT_RST;
      third_digit_r  <= DIGIT_RST;
      timeout_r      <= TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FIRST_DIGIT:   first_digit_r  <= pwdata[DIGIT_W-1:0];
        REG_SECOND_DIGIT:  second_digit_r <= pwdata[DIGIT_W-1:0];
        REG_THIRD_DIGIT:   third_digit_r  <= pwdata[DIGIT_W-1:0];
        REG_TIMEOUT_TICKS: timeout_r      <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick update: latch press, advance timer, then fire one transition
  assign pending_in  = pending_r || in_press;
  assign elapsed_adv = (timer_on_r && elapsed_r != TICK_MAX) ? elapsed_r + 16'd1 : elapsed_r;
  assign timed_out   = timer_on_r && (elapsed_adv >= timeout_r);

  always_comb begin
    unique case (digit_idx_r)
      IDX_DIGIT1: cur_digit = first_digit_r;
      IDX_DIGIT2: cur_digit = second_digit_r;
      default:    cur_digit = third_digit_r;
    endcase
  end
  assign cur_digit_ext = {1'b0, cur_digit};

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    digit_idx_nxt = digit_idx_r;
    timer_on_nxt  = timer_on_r;
    elapsed_nxt   = elapsed_adv;
    pending_nxt   = pending_in;
    unlock_nxt    = unlock_r;
    unique case (phase_r) inside
      PH_IDLE: begin
        if (pending_in) begin
          pending_nxt   = 1'b0;
          count_nxt     = 5'd1;
          timer_on_nxt  = 1'b1;
          elapsed_nxt   = '0;
          digit_idx_nxt = IDX_DIGIT1;
          phase_nxt     = PH_CHECK1;
        end
      end
      PH_CHECK1, PH_CHECK2, PH_CHECK3: begin
        if (timed_out || count_r > cur_digit_ext) begin
          phase_nxt = PH_IDLE;
        end else if (pending_in) begin
          pending_nxt  = 1'b0;
          count_nxt    = (count_r != COUNT_MAX) ? count_r + 5'd1 : count_r;
          timer_on_nxt = 1'b1;
          elapsed_nxt  = '0;
        end else if (count_r == cur_digit_ext) begin
          phase_nxt = phase_t'(phase_r + 3'd1);
        end
      end
      PH_WAIT1, PH_WAIT2, PH_WAIT3: begin
        if (timed_out) begin
          if (phase_r == PH_WAIT3) begin
            unlock_nxt = !unlock_r;
            phase_nxt  = PH_ACCEPTED;
          end else begin
            count_nxt     = '0;
            timer_on_nxt  = 1'b0;
            digit_idx_nxt = (phase_r == PH_WAIT1) ? IDX_DIGIT2 : IDX_DIGIT3;
            phase_nxt     = phase_t'(phase_r + 3'd1);
          end
        end else if (pending_in) begin
          // press during the settle wait aborts entry, unless the wait times out on that tick
          pending_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
        end
      end
      PH_ACCEPTED: phase_nxt = PH_IDLE;
      default:     phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      digit_idx_r <= IDX_DIGIT1;
      timer_on_r  <= 1'b0;
      elapsed_r   <= '0;
      pending_r   <= 1'b0;
      unlock_r    <= 1'b0;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      digit_idx_r <= digit_idx_nxt;
      timer_on_r  <= timer_on_nxt;
      elapsed_r   <= elapsed_nxt;
      pending_r   <= pending_nxt;
      unlock_r    <= unlock_nxt;
    end
  end

  // Result register; the lock flag is read straight from its state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_phase_r <= phase_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_idx_r != 2'd3)
    else $error("digit index reached an unused value");

  a_timer_sat: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && timer_on_r && elapsed_r == TICK_MAX && phase_r == PH_IDLE && !pending_in
    |=> elapsed_r == TICK_MAX)
    else $error("running timer left saturation in idle");

  a_unlock_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_nxt != PH_ACCEPTED |=> unlock_r == $past(unlock_r))
    else $error("lock flag changed without a full code");

  a_out_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !in_accept |=> out_phase_r == $past(out_phase_r))
    else $error("result phase changed without a new tick");
`endif

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcl_pkg::*;

  typedef struct packed {
    logic   unlocked;
    phase_t phase;
  } lock_view_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        press;
    logic        typed;
    logic        exp_open;
    phase_t      exp_phase;
    reg_idx_t    sel;
    logic [15:0] value;
  } plan_row_t;

  typedef enum {KEY_CLEAN, KEY_EXTRA, KEY_SHORT, KEY_SETTLE_PRESS} keying_t;

  localparam int PLAN_LEN = 33;

  // kind, press, typed, exp_open, exp_phase, register, value
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_TICK,  1'b0, 1'b1, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b1, 1'b0, PH_CHECK1,   REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    // zero timeout: any running timer expires at once
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_TIMEOUT_TICKS, 16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    // zero second digit: accepted at once, then a wait with the timer off
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_SECOND_DIGIT,  16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd2},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_SECOND_DIGIT,  16'd1},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_THIRD_DIGIT,   16'd1},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_TIMEOUT_TICKS, 16'd2},
    // full code 2-1-1
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b1, 1'b1, PH_ACCEPTED, REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b1, 1'b1, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    // overshoot, with a press on the aborting tick left pending
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b1, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, PH_IDLE,     REG_FIRST_DIGIT,   16'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_press;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_unlocked;
  logic [2:0]  out_phase;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pulse_count_code_lock dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_press     (in_press),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_unlocked (out_unlocked),
    .out_phase    (out_phase),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Lock state as the block should hold it
  phase_t             lk_phase;
  logic [COUNT_W-1:0] lk_count;
  logic [IDX_W-1:0]   lk_digit;
  logic               lk_timer_on;
  logic [TICK_W-1:0]  lk_elapsed;
  logic               lk_pending;
  logic               lk_open;
  logic [DIGIT_W-1:0] code_digit [3];
  logic [TICK_W-1:0]  idle_limit;

  lock_view_t views_due [$];
  bit         valid_up;
  bit         idle_on;
  int         stall_left;
  int         ticks_sent;
  int         reg_writes;
  int         checked;
  int         accepts;
  int         mism;

  function automatic lock_view_t lock_tick(input logic p);
    lock_view_t         v;
    logic [DIGIT_W-1:0] goal;
    logic               expired;
    if (p) lk_pending = 1'b1;
    if (lk_timer_on && lk_elapsed != TICK_MAX) lk_elapsed++;
    goal = (lk_digit == IDX_DIGIT1) ? code_digit[0] :
           (lk_digit == IDX_DIGIT2) ? code_digit[1] : code_digit[2];
    expired = lk_timer_on && lk_elapsed >= idle_limit;
    case (lk_phase)
      PH_IDLE: begin
        if (lk_pending) begin
          lk_pending  = 1'b0;
          lk_count    = 5'd1;
          lk_timer_on = 1'b1;
          lk_elapsed  = '0;
          lk_digit    = IDX_DIGIT1;
          lk_phase    = PH_CHECK1;
        end
      end
      PH_CHECK1, PH_CHECK2, PH_CHECK3: begin
        if (expired) begin
          lk_phase = PH_IDLE;
        end else if (lk_count > goal) begin
          lk_phase = PH_IDLE;
        end else if (lk_pending) begin
          lk_pending = 1'b0;
          if (lk_count != COUNT_MAX) lk_count++;
          lk_timer_on = 1'b1;
          lk_elapsed  = '0;
        end else if (lk_count == goal) begin
          lk_phase = phase_t'(lk_phase + 3'd1);
        end
      end
      PH_WAIT1, PH_WAIT2, PH_WAIT3: begin
        if (expired) begin
          if (lk_phase == PH_WAIT3) begin
            lk_open  = !lk_open;
            lk_phase = PH_ACCEPTED;
          end else begin
            lk_count    = '0;
            lk_timer_on = 1'b0;
            lk_digit    = (lk_phase == PH_WAIT1) ? IDX_DIGIT2 : IDX_DIGIT3;
            lk_phase    = phase_t'(lk_phase + 3'd1);
          end
        end else if (lk_pending) begin
          lk_pending = 1'b0;
          lk_phase   = PH_IDLE;
        end
      end
      default: lk_phase = PH_IDLE;
    endcase
    v.unlocked = lk_open;
    v.phase    = lk_phase;
    return v;
  endfunction

  task automatic stop_ticks();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic drain();
    stop_ticks();
    while (views_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(input logic p, input logic typed, input logic t_open,
                           input phase_t t_phase);
    lock_view_t seen;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      stop_ticks();
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_press <= p;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    seen = lock_tick(p);
    if (typed) begin
      seen.unlocked = t_open;
      seen.phase    = t_phase;
    end
    views_due.push_back(seen);
    ticks_sent++;
  endtask

  task automatic tick(input logic p);
    send_tick(p, 1'b0, 1'b0, PH_IDLE);
  endtask

  task automatic write_reg(input reg_idx_t sel, input logic [31:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_FIRST_DIGIT:   code_digit[0] = val[DIGIT_W-1:0];
      REG_SECOND_DIGIT:  code_digit[1] = val[DIGIT_W-1:0];
      REG_THIRD_DIGIT:   code_digit[2] = val[DIGIT_W-1:0];
      REG_TIMEOUT_TICKS: idle_limit    = val[TICK_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic key_zeros(input int n);
    repeat (n) tick(1'b0);
  endtask

  // Press n times, keeping every gap short enough to beat the timeout if any gap can
  task automatic key_digit(input int n);
    int gap_max;
    gap_max = (idle_limit >= 2) ? idle_limit - 2 : 0;
    for (int k = 0; k < n; k++) begin
      tick(1'b1);
      if (k < n - 1) key_zeros($urandom_range(0, gap_max));
    end
  endtask

  task automatic key_code();
    keying_t how;
    int      r;
    int      bad;
    int      n;
    r = $urandom_range(0, 9);
    if (r < 7) how = KEY_CLEAN;
    else if (r == 7) how = KEY_EXTRA;
    else if (r == 8) how = KEY_SHORT;
    else how = KEY_SETTLE_PRESS;
    bad = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      n = code_digit[i];
      if (i == bad && how == KEY_EXTRA) n++;
      if (i == bad && how == KEY_SHORT && n > 0) n--;
      if (i == 0 && n == 0) n = 1;
      key_digit(n);
      if (i == bad && how == KEY_SETTLE_PRESS) begin
        key_zeros($urandom_range(1, idle_limit + 1));
        tick(1'b1);
      end
      key_zeros(idle_limit + $urandom_range(1, 2));
    end
    key_zeros(2);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) tick($urandom_range(0, 1));
    end
  endtask

  // Receiver side: drop ready in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin : watch
    lock_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (views_due.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected result: unlocked=%0b phase=%0d", out_unlocked, out_phase);
      end else begin
        want = views_due.pop_front();
        checked++;
        if (out_phase == PH_ACCEPTED) accepts++;
        if (out_unlocked !== want.unlocked || out_phase !== want.phase) begin
          mism++;
          if (mism <= 10)
            $display("result %0d: expected unlocked=%0b phase=%0d, got unlocked=%0b phase=%0d",
                     checked, want.unlocked, want.phase, out_unlocked, out_phase);
        end
      end
    end
  end

  initial begin : stimulus
    int rand_start;
    int r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_press = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_on  = 1'b0;

    lk_phase    = PH_IDLE;
    lk_count    = '0;
    lk_digit    = IDX_DIGIT1;
    lk_timer_on = 1'b0;
    lk_elapsed  = '0;
    lk_pending  = 1'b0;
    lk_open     = 1'b0;
    code_digit[0] = DIGIT_RST;
    code_digit[1] = DIGIT_RST;
    code_digit[2] = DIGIT_RST;
    idle_limit    = TIMEOUT_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE)
        write_reg(PLAN[i].sel, {16'd0, PLAN[i].value});
      else
        send_tick(PLAN[i].press, PLAN[i].typed, PLAN[i].exp_open, PLAN[i].exp_phase);
    end

    // Longest timeout: a settle wait that a press cuts short
    write_reg(REG_FIRST_DIGIT, 32'd1);
    write_reg(REG_SECOND_DIGIT, 32'd15);
    write_reg(REG_THIRD_DIGIT, 32'd0);
    write_reg(REG_TIMEOUT_TICKS, {16'd0, TICK_MAX});
    idle_on = 1'b0;
    tick(1'b1);
    key_zeros(40);
    tick(1'b1);
    tick(1'b1);

    rand_start = ticks_sent;
    while (ticks_sent - rand_start < 1900) begin
      idle_on = (ticks_sent - rand_start < 1500) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 3; i++) begin
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        write_reg(reg_idx_t'(i), ($urandom() & 32'hFFFF_FFF0) | r);
      end
      r = $urandom_range(0, 15);
      if (r == 0) r = 0;
      else if (r == 1) r = 1;
      else if (r <= 11) r = $urandom_range(2, 8);
      else r = $urandom_range(9, 40);
      write_reg(REG_TIMEOUT_TICKS, ($urandom() & 32'hFFFF_0000) | r);
      repeat ($urandom_range(4, 8)) key_code();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d ticks over %0d register writes; %0d results checked, %0d codes accepted.",
             ticks_sent, reg_writes, checked, accepts);
    $display("Mismatches: %0d", mism);
    if (mism == 0) begin
      $display("PASS pulse_count_code_lock");
    end else begin
      $display("FAIL pulse_count_code_lock");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL pulse_count_code_lock");
    $finish;
  end

endmodule
